>>> src/indexed_list_store_core_defines.svh
// assertion macros used by the top-level rtl file
`ifndef INDEXED_LIST_STORE_CORE_DEFINES_SVH
`define INDEXED_LIST_STORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check held off while reset is low
`define ILS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also runs through reset
`define ILS_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ILS_ASSERT(lbl, clk, prop, msg)
`endif

`endif

>>> src/ils_pkg.sv
package ils_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int DATA_W = 38;
    localparam int STAT_W = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_DELETE = 3'd2,
        FN_MAX    = 3'd3,
        FN_SUM    = 3'd4,
        FN_DUMP   = 3'd5
    } t_func;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_end;
    } t_dp_stat;

endpackage

>>> src/ils_ctrl.sv
module ils_ctrl import ils_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.need_scan ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_end) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands and busy
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

>>> src/ils_dp.sv
module ils_dp import ils_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VAL_W-1:0]    i_item_value,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_data,
    output logic [STAT_W-1:0]   o_status,
    output logic                o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [DATA_W-1:0] MAX_INIT = {{(DATA_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    // latched request
    logic [FUNC_W-1:0] r_func;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_value;

    // list cells and count
    logic [VAL_W-1:0] r_entries [CAPACITY];
    logic [VAL_W-1:0] up_src    [CAPACITY];
    logic [VAL_W-1:0] dn_src    [CAPACITY];
    logic [CW-1:0]    r_count;

    // scan state
    logic [IW-1:0]     r_idx;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] n_acc;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_last;

    t_status           st;
    logic              full;
    logic              empty;
    logic [POS_W-1:0]  cnt_ext;
    logic [CW-1:0]     cnt_m1;
    logic [IW-1:0]     rd_sel;
    logic [VAL_W-1:0]  rd_data;
    logic [DATA_W-1:0] rd_ext;
    logic              do_app;
    logic              do_ins;
    logic              do_del;
    logic              scan_end;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_pos   <= i_position;
            r_value <= i_item_value;
        end
    end

    // range and capacity checks
    assign cnt_ext = POS_W'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign cnt_m1  = r_count - 1'b1;

    always_comb begin
        st = ST_OK;
        unique case (r_func)
            FN_APPEND: begin
                if (full) st = ST_FULL;
            end
            FN_INSERT: begin
                priority if (r_pos > cnt_ext) st = ST_RANGE;
                else if (full)                st = ST_FULL;
            end
            FN_DELETE, FN_MAX: begin
                priority if (empty)            st = ST_EMPTY;
                else if (r_pos >= cnt_ext)     st = ST_RANGE;
            end
            FN_SUM, FN_DUMP: begin
                if (empty) st = ST_EMPTY;
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    assign do_app = i_cmd.exec && (st == ST_OK) && (r_func == FN_APPEND);
    assign do_ins = i_cmd.exec && (st == ST_OK) && (r_func == FN_INSERT);
    assign do_del = i_cmd.exec && (st == ST_OK) && (r_func == FN_DELETE);

    assign o_stat.need_scan = (st == ST_OK) &&
        ((r_func == FN_MAX) || (r_func == FN_SUM) || (r_func == FN_DUMP));
    assign scan_end        = (r_idx == cnt_m1[IW-1:0]);
    assign o_stat.scan_end = scan_end;

    // single read port: delete victim or scan element
    assign rd_sel  = i_cmd.exec ? r_pos[IW-1:0] : r_idx;
    assign rd_data = r_entries[rd_sel];
    assign rd_ext  = {{(DATA_W-VAL_W){rd_data[VAL_W-1]}}, rd_data};

    // shifting cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g > 0) begin : g_up
            assign up_src[g] = r_entries[g-1];
        end else begin : g_up0
            assign up_src[g] = r_entries[g];
        end
        if (g < CAPACITY - 1) begin : g_dn
            assign dn_src[g] = r_entries[g+1];
        end else begin : g_dn0
            assign dn_src[g] = r_entries[g];
        end

        always_ff @(posedge i_clk) begin
            priority if ((do_ins && (r_pos == POS_W'(g))) ||
                         (do_app && (r_count == CW'(g)))) begin
                r_entries[g] <= r_value;
            end else if (do_ins && (r_pos < POS_W'(g))) begin
                r_entries[g] <= up_src[g];
            end else if (do_del && (r_pos <= POS_W'(g))) begin
                r_entries[g] <= dn_src[g];
            end
        end
    end

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_app || do_ins) begin
            r_count <= r_count + 1'b1;
        end else if (do_del) begin
            r_count <= r_count - 1'b1;
        end
    end

    // reduction step
    always_comb begin
        if (r_func == FN_SUM) begin
            n_acc = r_acc + rd_ext;
        end else if ($signed(rd_ext) > $signed(r_acc)) begin
            n_acc = rd_ext;
        end else begin
            n_acc = r_acc;
        end
    end

    // scan pointer and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_idx <= (r_func == FN_MAX) ? r_pos[IW-1:0] : '0;
            r_acc <= (r_func == FN_MAX) ? MAX_INIT : '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.exec && !o_stat.need_scan) ||
                           (i_cmd.scan && (scan_end || (r_func == FN_DUMP)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data   <= do_del ? rd_ext : '0;
            r_out_status <= st;
            r_out_last   <= 1'b1;
        end else if (i_cmd.scan) begin
            r_out_data   <= (r_func == FN_DUMP) ? rd_ext : n_acc;
            r_out_status <= ST_OK;
            r_out_last   <= scan_end;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule

>>> src/indexed_list_store_core.sv
// ordered list store with index-based insert and delete
// request: start with i_func, i_position, i_item_value; taken when start is
//   high and busy is low. busy is high while a request is being worked on.
// result: o_valid strobes for one cycle with o_data, o_status and o_last;
//   the receiver cannot stall, every strobe is a delivered result.
// append, insert, delete, errors and unused codes: the result strobes in
//   the same cycle that busy drops; the next request may be given in that
//   same cycle.
// max: from index up to the last element; sum: over all elements;
//   dump: count results on consecutive cycles, last marked.
// the reduction walks the single read port of the list cells one element
//   per cycle.
// insert and delete update all cells at and above the position together.
// reset (i_rst_n low, synchronous) empties the list and returns to idle;
//   cell contents are not cleared and are never read before written.
`include "indexed_list_store_core_defines.svh"

module indexed_list_store_core import ils_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VAL_W-1:0]    i_item_value,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_data,
    output logic [STAT_W-1:0]   o_status,
    output logic                o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller
    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath
    ils_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    // checks
    `ILS_ASSERT_RST(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "request not taken")
    `ILS_ASSERT_RST(a_dump_burst, i_clk, i_rst_n, (o_valid && !o_last) |=> o_valid, "dump gap")
    `ILS_ASSERT_RST(a_result_after_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "stray result")
    `ILS_ASSERT_RST(a_error_single, i_clk, i_rst_n, (o_valid && (o_status != ST_OK)) |-> o_last, "error not last")

endmodule
